@@ hw/rtl/csb_pkg.sv @@
// shared constants, codes and lane interface types of the contrast stretch block
package csb_pkg;

   // channel and arithmetic widths
   localparam int PIX_W          = 8;
   localparam int LANES          = 3;
   localparam int NUM_W          = PIX_W + 1;
   localparam int DEN_W          = PIX_W + 1;
   localparam int PROD_W         = PIX_W + NUM_W;
   localparam int QUO_STEPS      = PIX_W;
   localparam int STEP_W         = $clog2(QUO_STEPS);
   localparam int MAX_PIXELS_DEF = 4096;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   // register indexes of the csr port
   localparam logic CSR_OUT_LOW  = 1'b0;
   localparam logic CSR_OUT_HIGH = 1'b1;

   // register reset values
   localparam logic [PIX_W-1:0] OUT_LOW_RST  = 8'd0;
   localparam logic [PIX_W-1:0] OUT_HIGH_RST = 8'd255;
   localparam logic [PIX_W-1:0] LOWEST_RST   = 8'd255;
   localparam logic [PIX_W-1:0] HIGHEST_RST  = 8'd0;

   // control shared by all lanes
   typedef struct packed {
      logic             start;
      logic [PIX_W-1:0] lowest;
      logic [DEN_W-1:0] den;
      logic [PIX_W-1:0] out_low;
      logic [PIX_W-1:0] out_high;
   } lane_ctl_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] quo;
   } lane_res_type;

endpackage

@@ hw/rtl/csb_lane.sv @@
// one channel lane: offset, scale multiply and radix-2 restoring divide
module csb_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  csb_pkg::lane_ctl_type ctl,
   input  logic [csb_pkg::PIX_W-1:0] chan,
   output csb_pkg::lane_res_type res
);
   import csb_pkg::*;

   logic signed [NUM_W:0] num;
   logic [NUM_W-1:0]      num_pos;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W:0]       diff;
   logic                  fits;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [PROD_W-1:0]     rem_ff, rem_in;
   logic [PROD_W-1:0]     dsh_ff, dsh_in;
   logic [PIX_W-1:0]      quo_ff, quo_in;

   // offset numerator, clamped at zero, then scaled by out_high
   assign num = $signed({2'b00, chan}) + $signed({2'b00, ctl.out_low})
              - $signed({2'b00, ctl.lowest});
   assign num_pos = num[NUM_W] ? '0 : num[NUM_W-1:0];
   assign prod = PROD_W'(ctl.out_high) * PROD_W'(num_pos);

   // trial subtract of the shifted divisor
   assign diff = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign fits = !diff[PROD_W];

   // load on start, then one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = prod;
         dsh_in  = PROD_W'(ctl.den) << (QUO_STEPS - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[PROD_W-1:0] : rem_ff;
         quo_in  = {quo_ff[PIX_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign res.done = done_ff;
   assign res.quo  = quo_ff;

endmodule

@@ hw/rtl/csb_merge.sv @@
// merge stage: combines lane quotients and frame flags into the response register
module csb_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [csb_pkg::LANES-1:0][csb_pkg::PIX_W-1:0] quo,
   input  logic                  zero_den,
   input  logic                  last,
   input  logic                  err,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [csb_pkg::PIX_W-1:0] rsp_out_blue,
   output logic [csb_pkg::PIX_W-1:0] rsp_out_green,
   output logic [csb_pkg::PIX_W-1:0] rsp_out_red,
   output logic                  rsp_last_pixel,
   output logic                  rsp_error
);
   import csb_pkg::*;

   logic                            valid_ff, valid_in;
   logic [LANES-1:0][PIX_W-1:0]     chan_ff, chan_in;
   logic                            last_ff;
   logic                            err_ff;

   // free when empty or when the held word leaves this cycle
   assign ready = !valid_ff || !rsp_stall;

   // zero denominator forces all channels to zero
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         chan_in[i] = zero_den ? '0 : quo[i];
      end
      if (push) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (push) begin
         chan_ff <= chan_in;
         last_ff <= last;
         err_ff  <= err || zero_den;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_blue   = chan_ff[0];
   assign rsp_out_green  = chan_ff[1];
   assign rsp_out_red    = chan_ff[2];
   assign rsp_last_pixel = last_ff;
   assign rsp_error      = err_ff;

endmodule

@@ hw/rtl/contrast_stretch_bgr.sv @@
// top level: frame store, min/max tracking, emit sequencing and three stretch lanes
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  req_type, req_blue, req_green, req_red
//   rsp      out  rsp_valid/rsp_stall  out_blue/green/red, last_pixel, error
//   csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
// a load is taken in the idle state and leaves the block idle; an emit that yields a pixel
// holds the input through memory read, lane load, 8 steps of the radix-2 divider in each
// channel lane and the hand-over to the response register.
// an emit with nothing left to return also leaves the block idle.
// reset clears counters and flags, sets lowest to 255, highest to 0, out_low 0,
// out_high 255; the frame store is not cleared.
// a stalled response holds in the merge register; the next emit runs its lanes
// and waits for that register before it hands over.
module contrast_stretch_bgr #(
   parameter int MAX_PIXELS = csb_pkg::MAX_PIXELS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [csb_pkg::PIX_W-1:0] req_blue,
   input  logic [csb_pkg::PIX_W-1:0] req_green,
   input  logic [csb_pkg::PIX_W-1:0] req_red,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [csb_pkg::PIX_W-1:0] rsp_out_blue,
   output logic [csb_pkg::PIX_W-1:0] rsp_out_green,
   output logic [csb_pkg::PIX_W-1:0] rsp_out_red,
   output logic                      rsp_last_pixel,
   output logic                      rsp_error,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [csb_pkg::PIX_W-1:0] csr_wdata
);
   import csb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int WORD_W = LANES * PIX_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DIV  = 3'b100
   } state_type;

   function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   pix_cnt_ff, pix_cnt_in;
   logic [CNT_W-1:0]   emit_idx_ff, emit_idx_in;
   logic [PIX_W-1:0]   lo_ff, lo_in;
   logic [PIX_W-1:0]   hi_ff, hi_in;
   logic               emitting_ff, emitting_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   logic               err_ff, err_in;
   logic               zden_ff, zden_in;
   logic [PIX_W-1:0]   out_low_ff;
   logic [PIX_W-1:0]   out_high_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [WORD_W-1:0]  pix_mem [MAX_PIXELS];

   logic               accept;
   logic               wr_en;
   logic               rd_en;
   logic               lane_start;
   logic               push;
   logic               merge_ready;
   logic [CNT_W-1:0]   base_cnt;
   logic [CNT_W-1:0]   base_idx;
   logic [PIX_W-1:0]   base_lo;
   logic [PIX_W-1:0]   base_hi;
   logic               base_ovf;
   logic               full;
   logic [PIX_W-1:0]   pix_min;
   logic [PIX_W-1:0]   pix_max;
   logic [DEN_W:0]     den_full;
   logic               zero_den;
   lane_ctl_type       lane_ctl;
   lane_res_type       lane_res [LANES];
   logic [LANES-1:0][PIX_W-1:0] lane_quo;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // a load after emitting starts the frame over
   assign base_cnt = emitting_ff ? '0 : pix_cnt_ff;
   assign base_idx = emitting_ff ? '0 : emit_idx_ff;
   assign base_lo  = emitting_ff ? LOWEST_RST : lo_ff;
   assign base_hi  = emitting_ff ? HIGHEST_RST : hi_ff;
   assign base_ovf = emitting_ff ? 1'b0 : ovf_ff;
   assign full     = (base_cnt >= CNT_W'(MAX_PIXELS));
   assign pix_min  = min2(min2(req_blue, req_green), req_red);
   assign pix_max  = max2(max2(req_blue, req_green), req_red);

   // stretch denominator
   assign den_full = {2'b00, hi_ff} - {2'b00, lo_ff} + {2'b00, out_low_ff};
   assign zero_den = (den_full == '0);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pix_cnt_in  = pix_cnt_ff;
      emit_idx_in = emit_idx_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      emitting_in = emitting_ff;
      ovf_in      = ovf_ff;
      last_in     = last_ff;
      err_in      = err_ff;
      zden_in     = zden_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      lane_start  = 1'b0;
      push        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  emitting_in = 1'b0;
                  emit_idx_in = base_idx;
                  pix_cnt_in  = base_cnt;
                  lo_in       = base_lo;
                  hi_in       = base_hi;
                  ovf_in      = base_ovf;
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en      = 1'b1;
                     pix_cnt_in = base_cnt + CNT_W'(1);
                     lo_in      = min2(base_lo, pix_min);
                     hi_in      = max2(base_hi, pix_max);
                  end
               end else begin
                  emitting_in = 1'b1;
                  if (emit_idx_ff < pix_cnt_ff) begin
                     rd_en       = 1'b1;
                     emit_idx_in = emit_idx_ff + CNT_W'(1);
                     last_in     = ((emit_idx_ff + CNT_W'(1)) == pix_cnt_ff);
                     err_in      = ovf_ff;
                     zden_in     = zero_den;
                     state_in    = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            lane_start = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (lane_res[0].done && merge_ready) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pix_cnt_ff  <= '0;
         emit_idx_ff <= '0;
         lo_ff       <= LOWEST_RST;
         hi_ff       <= HIGHEST_RST;
         emitting_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pix_cnt_ff  <= pix_cnt_in;
         emit_idx_ff <= emit_idx_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         emitting_ff <= emitting_in;
         ovf_ff      <= ovf_in;
      end
   end

   // per-item flags carried to the merge stage
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      err_ff  <= err_in;
      zden_ff <= zden_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_low_ff  <= OUT_LOW_RST;
         out_high_ff <= OUT_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_OUT_LOW) begin
            out_low_ff <= csr_wdata;
         end
         if (csr_index == CSR_OUT_HIGH) begin
            out_high_ff <= csr_wdata;
         end
      end
   end

   // frame store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_mem[base_cnt[ADDR_W-1:0]] <= {req_red, req_green, req_blue};
      end
      if (rd_en) begin
         rd_data_ff <= pix_mem[emit_idx_ff[ADDR_W-1:0]];
      end
   end

   // lanes: blue, green, red
   assign lane_ctl.start    = lane_start;
   assign lane_ctl.lowest   = lo_ff;
   assign lane_ctl.den      = den_full[DEN_W-1:0];
   assign lane_ctl.out_low  = out_low_ff;
   assign lane_ctl.out_high = out_high_ff;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      csb_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .chan  (rd_data_ff[g*PIX_W +: PIX_W]),
         .res   (lane_res[g])
      );
      assign lane_quo[g] = lane_res[g].quo;
   end

   csb_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .quo            (lane_quo),
      .zero_den       (zden_ff),
      .last           (last_ff),
      .err            (err_ff),
      .ready          (merge_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_error      (rsp_error)
   );

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pix_cnt_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count beyond capacity");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      emit_idx_ff <= pix_cnt_ff)
      else $error("emit index passed pixel count");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      push |-> (lane_res[0].done && lane_res[1].done && lane_res[2].done))
      else $error("merge took a word before all lanes finished");

   a_range: assert property (@(posedge clock) disable iff (reset)
      (pix_cnt_ff != '0) |-> (lo_ff <= hi_ff))
      else $error("lowest above highest in a non-empty frame");

   a_push_out: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_valid)
      else $error("merged word did not reach the response port");

endmodule

@@ sim/contrast_stretch_bgr_tb.sv @@
// self-checking testbench for the bgr contrast stretch block
`timescale 1ns / 100ps

module contrast_stretch_bgr_tb;
   import csb_pkg::*;

   localparam int MAX_PIX   = MAX_PIXELS_DEF;
   localparam int MEM_AW    = $clog2(MAX_PIX);
   localparam int SETTLE    = 16;
   localparam int END_WAIT  = 40;
   localparam int LONG_HOLD = 300;
   localparam int LIMIT     = 4000;

   // how the channels of a loaded frame are drawn
   typedef enum int {FILL_WIDE, FILL_NARROW, FILL_FLAT, FILL_RAILS} fill_kind_type;

   // one stretched pixel as it leaves the block
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             last_pixel;
      logic             err_flag;
   } stretch_word_type;

   // frame tracking and expected pixel queue
   class stretch_scoreboard;
      logic [3*PIX_W-1:0] frame_mem [MAX_PIX];
      int unsigned        pix_count;
      int unsigned        emit_idx;
      logic [PIX_W-1:0]   lowest;
      logic [PIX_W-1:0]   highest;
      logic [PIX_W-1:0]   out_low;
      logic [PIX_W-1:0]   out_high;
      bit                 emitting;
      bit                 overflowed;
      stretch_word_type   pixel_q [$];
      int                 mismatches;

      function new();
         start_frame();
         out_low    = OUT_LOW_RST;
         out_high   = OUT_HIGH_RST;
         mismatches = 0;
      endfunction

      function void start_frame();
         pix_count  = 0;
         emit_idx   = 0;
         lowest     = LOWEST_RST;
         highest    = HIGHEST_RST;
         emitting   = 0;
         overflowed = 0;
      endfunction

      function void write_reg(logic idx, logic [PIX_W-1:0] val);
         if (idx == CSR_OUT_LOW) out_low = val;
         else out_high = val;
      endfunction

      function void track(logic [PIX_W-1:0] c);
         if (c < lowest) lowest = c;
         if (c > highest) highest = c;
      endfunction

      function logic [PIX_W-1:0] stretch_channel(logic [PIX_W-1:0] c, int den);
         int num;
         int q;
         num = int'(c) + int'(out_low) - int'(lowest);
         if (num < 0) num = 0;
         q = (int'(out_high) * num) / den;
         if (q > 255) q = 255;
         return q[PIX_W-1:0];
      endfunction

      // update frame state for one accepted request word
      function void note_request(logic typ, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] r);
         stretch_word_type   w;
         logic [3*PIX_W-1:0] px;
         int                 den;
         if (typ == REQ_LOAD) begin
            if (emitting) start_frame();
            if (pix_count >= MAX_PIX) begin
               overflowed = 1;
               return;
            end
            frame_mem[pix_count[MEM_AW-1:0]] = {r, g, b};
            pix_count++;
            track(b);
            track(g);
            track(r);
            return;
         end
         emitting = 1;
         if (emit_idx >= pix_count) return;
         px  = frame_mem[emit_idx[MEM_AW-1:0]];
         den = int'(highest) - int'(lowest) + int'(out_low);
         w.err_flag = overflowed;
         if (den <= 0) begin
            w.blue     = '0;
            w.green    = '0;
            w.red      = '0;
            w.err_flag = 1'b1;
         end else begin
            w.blue  = stretch_channel(px[PIX_W-1:0], den);
            w.green = stretch_channel(px[2*PIX_W-1:PIX_W], den);
            w.red   = stretch_channel(px[3*PIX_W-1:2*PIX_W], den);
         end
         w.last_pixel = (emit_idx + 1 == pix_count);
         emit_idx++;
         pixel_q.push_back(w);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
      endfunction

      // compare one accepted response word with the oldest expected pixel
      function void check_pixel(stretch_word_type got);
         stretch_word_type want;
         if (pixel_q.size() == 0) begin
            flag($sformatf("unexpected word b=%0d g=%0d r=%0d last=%0b err=%0b",
                           got.blue, got.green, got.red, got.last_pixel, got.err_flag));
            return;
         end
         want = pixel_q.pop_front();
         if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
             got.last_pixel !== want.last_pixel || got.err_flag !== want.err_flag)
            flag({$sformatf("exp b=%0d g=%0d r=%0d last=%0b err=%0b, ",
                            want.blue, want.green, want.red, want.last_pixel,
                            want.err_flag),
                  $sformatf("got b=%0d g=%0d r=%0d last=%0b err=%0b",
                            got.blue, got.green, got.red, got.last_pixel,
                            got.err_flag)});
      endfunction

      function int outstanding();
         return pixel_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_type = REQ_LOAD;
   logic [PIX_W-1:0] req_blue = '0;
   logic [PIX_W-1:0] req_green = '0;
   logic [PIX_W-1:0] req_red = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [PIX_W-1:0] rsp_out_blue;
   logic [PIX_W-1:0] rsp_out_green;
   logic [PIX_W-1:0] rsp_out_red;
   logic             rsp_last_pixel;
   logic             rsp_error;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = CSR_OUT_LOW;
   logic [PIX_W-1:0] csr_wdata = '0;

   stretch_scoreboard sb = new;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   contrast_stretch_bgr #(.MAX_PIXELS(MAX_PIX)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_error      (rsp_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitors for all three channels plus the stuck-run watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_pixel({rsp_out_blue, rsp_out_green, rsp_out_red,
                            rsp_last_pixel, rsp_error});
         if (req_valid && !req_stall)
            sb.note_request(req_type, req_blue, req_green, req_red);
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // offer one request word, entered and left at a falling edge
   task automatic send_word(logic typ, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_type  = typ;
      req_blue  = b;
      req_green = g;
      req_red   = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // emit carries junk channels, which the block ignores
   task automatic emit_pixel();
      send_word(REQ_EMIT, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
   endtask

   // wait for every expected pixel, then for any trailing no-result work
   task automatic wait_drain();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [PIX_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // new register setting while the block is idle; extremes are favored
   task automatic retune(int pick);
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] hi;
      case (pick)
         0: begin lo = 8'd0;   hi = 8'd255; end
         1: begin lo = 8'd255; hi = 8'd0;   end
         2: begin lo = 8'd0;   hi = 8'd0;   end
         3: begin lo = 8'd255; hi = 8'd255; end
         4: begin lo = 8'd1;   hi = 8'd254; end
         default: begin lo = PIX_W'($urandom); hi = PIX_W'($urandom); end
      endcase
      wait_drain();
      if ($urandom_range(3) != 0) write_reg(CSR_OUT_LOW, lo);
      if ($urandom_range(3) != 0) write_reg(CSR_OUT_HIGH, hi);
   endtask

   function automatic logic [PIX_W-1:0] pick_channel(fill_kind_type kind,
                                                     logic [PIX_W-1:0] base, int span);
      int v;
      case (kind)
         FILL_NARROW: begin
            v = int'(base) + $urandom_range(span);
            if (v > 255) v = 255;
         end
         FILL_FLAT:  v = base;
         FILL_RAILS: v = $urandom_range(1) ? 255 : 0;
         default:    v = $urandom_range(255);
      endcase
      return v[PIX_W-1:0];
   endfunction

   // one frame: loads, then mostly a full emit run, sometimes short or overlong
   task automatic random_frame();
      int               n_pix;
      int               n_emit;
      int               span;
      fill_kind_type    kind;
      logic [PIX_W-1:0] base;
      n_pix = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      if ($urandom_range(19) == 0) n_pix = 0;
      case ($urandom_range(19))
         0, 1, 2: n_emit = $urandom_range(n_pix);
         3, 4, 5: n_emit = n_pix + $urandom_range(3, 1);
         default: n_emit = n_pix;
      endcase
      case ($urandom_range(5))
         3:       kind = FILL_NARROW;
         4:       kind = FILL_FLAT;
         5:       kind = FILL_RAILS;
         default: kind = FILL_WIDE;
      endcase
      base = PIX_W'($urandom);
      span = $urandom_range(15);
      repeat (n_pix)
         send_word(REQ_LOAD, pick_channel(kind, base, span), pick_channel(kind, base, span),
                   pick_channel(kind, base, span));
      repeat (n_emit) emit_pixel();
   endtask

   task automatic run_phase(int target);
      int stop;
      stop = items_sent + target;
      while (items_sent < stop) begin
         if ($urandom_range(4) == 0) retune($urandom_range(5));
         random_frame();
      end
   endtask

   // receiver holds off while emits keep coming, so the input backs up
   task automatic hold_off_burst();
      repeat (16)
         send_word(REQ_LOAD, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
      req_valid = 1'b0;
      @(posedge clock);
      hold_token++;
      @(negedge clock);
      repeat (16) emit_pixel();
      wait_drain();
   endtask

   // short directed sequence at reset settings
   task automatic directed_checks();
      // emit on an empty frame gives nothing
      send_word(REQ_EMIT, 8'hFF, 8'h00, 8'hFF);
      send_word(REQ_LOAD, 8'h00, 8'h00, 8'h00);
      send_word(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF);
      send_word(REQ_LOAD, 8'h80, 8'h7F, 8'h01);
      send_word(REQ_LOAD, 8'h55, 8'hAA, 8'hFE);
      // full read-out plus one emit past the end
      repeat (5) emit_pixel();
      // load after emitting, flat frame gives a zero denominator
      send_word(REQ_LOAD, 8'h07, 8'h07, 8'h07);
      send_word(REQ_LOAD, 8'h07, 8'h07, 8'h07);
      repeat (2) emit_pixel();
      // partial read-out, then a fresh frame
      send_word(REQ_LOAD, 8'h10, 8'h20, 8'h30);
      send_word(REQ_LOAD, 8'h40, 8'h50, 8'h60);
      send_word(REQ_LOAD, 8'h70, 8'h80, 8'h90);
      emit_pixel();
      send_word(REQ_LOAD, 8'hC3, 8'h3C, 8'h5A);
      send_word(REQ_LOAD, 8'h01, 8'hFE, 8'h80);
      repeat (2) emit_pixel();
   endtask

   // main sequence
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_checks();

      // sender mostly busy, receiver stalls often
      send_idle_pct = 6;
      recv_idle_pct = 54;
      retune(1);
      run_phase(580);
      hold_off_burst();

      // sender gappy, receiver mostly ready
      send_idle_pct = 54;
      recv_idle_pct = 6;
      retune(2);
      run_phase(580);

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      retune(3);
      run_phase(560);
      retune(0);
      random_frame();

      wait_drain();
      repeat (END_WAIT) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
